@@ hdl/sft_pkg.sv @@
package sft_pkg;

  localparam int BODY_BYTES = 9;
  localparam int DATA_BYTES = BODY_BYTES - 1;
  localparam int IDX_W      = $clog2(DATA_BYTES);
  localparam int POS_W      = $clog2(BODY_BYTES);
  localparam int STEP_W     = 3;
  localparam int CFG_IDX_W  = 2;

  localparam logic [7:0] STX_BYTE = 8'h02;
  localparam logic [7:0] ETX_BYTE = 8'h03;
  localparam logic [7:0] ESC_BYTE = 8'h7D;
  localparam logic [7:0] ESC_XOR  = 8'h20;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_READ_CODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_CODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STATE_BYTE = 2'd2;

  // byte source select
  localparam logic [2:0] SRC_STX  = 3'd0;
  localparam logic [2:0] SRC_ETX  = 3'd1;
  localparam logic [2:0] SRC_ESC  = 3'd2;
  localparam logic [2:0] SRC_BODY = 3'd3;
  localparam logic [2:0] SRC_XOR  = 3'd4;

  // branch conditions
  localparam logic [1:0] COND_NONE   = 2'd0;
  localparam logic [1:0] COND_ACCEPT = 2'd1;
  localparam logic [1:0] COND_BODY   = 2'd2;

  // program steps
  localparam logic [STEP_W-1:0] ST_WAIT = 3'd0;
  localparam logic [STEP_W-1:0] ST_SOF  = 3'd1;
  localparam logic [STEP_W-1:0] ST_BODY = 3'd2;
  localparam logic [STEP_W-1:0] ST_XOR  = 3'd3;
  localparam logic [STEP_W-1:0] ST_EOF  = 3'd4;

  typedef struct packed {
    logic              accept;
    logic              emit;
    logic [2:0]        src;
    logic              last;
    logic              stuff;
    logic              pos_inc;
    logic [1:0]        cond;
    logic [STEP_W-1:0] esc_tgt;
    logic [STEP_W-1:0] jmp_tgt;
    logic [STEP_W-1:0] nxt_tgt;
  } ctrl_t;

  typedef struct packed {
    logic esc;
    logic at_end;
    logic adv;
  } stat_t;

  // microcode table
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = '0;
    case (step)
      ST_WAIT: begin
        w.accept  = 1'b1;
        w.cond    = COND_ACCEPT;
        w.jmp_tgt = ST_SOF;
        w.nxt_tgt = ST_WAIT;
      end
      ST_SOF: begin
        w.emit    = 1'b1;
        w.src     = SRC_STX;
        w.nxt_tgt = ST_BODY;
      end
      ST_BODY: begin
        w.emit    = 1'b1;
        w.src     = SRC_BODY;
        w.stuff   = 1'b1;
        w.pos_inc = 1'b1;
        w.cond    = COND_BODY;
        w.esc_tgt = ST_XOR;
        w.jmp_tgt = ST_EOF;
        w.nxt_tgt = ST_BODY;
      end
      ST_XOR: begin
        w.emit    = 1'b1;
        w.src     = SRC_XOR;
        w.pos_inc = 1'b1;
        w.cond    = COND_BODY;
        w.jmp_tgt = ST_EOF;
        w.nxt_tgt = ST_BODY;
      end
      ST_EOF: begin
        w.emit    = 1'b1;
        w.src     = SRC_ETX;
        w.last    = 1'b1;
        w.nxt_tgt = ST_WAIT;
      end
      default: begin
        w.nxt_tgt = ST_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

@@ hdl/stuffed_frame_transmitter_unit.sv @@
// channel   direction  handshake           word
// cfg       in         cfg_write           cfg_index, cfg_data
// in        in         in_valid/in_stall   is_write, address, data_word
// out       out        out_valid/out_stall out_byte, last_byte
//
// One command gives a frame of 11 to 20 bytes, one byte per cycle from the
// microcode sequencer unless output stalls; the wait step takes the command.
// Input is stalled for the whole frame; the next command is taken after ETX.
// Output stall holds the sequencer step; a registered output byte decouples it.
// Synchronous reset clears step, out_valid, pos, sum, cfg; write code gets 1.
module stuffed_frame_transmitter_unit
  import sft_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 is_write,
  input  logic [15:0]          address,
  input  logic [31:0]          data_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_byte,
  output logic                 last_byte
);

  ctrl_t ctrl;
  stat_t stat;

  assign in_stall = !ctrl.accept;

  sft_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  sft_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .is_write  (is_write),
    .address   (address),
    .data_word (data_word),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .last_byte (last_byte)
  );

endmodule

@@ hdl/sft_sequencer.sv @@
module sft_sequencer
  import sft_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  stat_t stat,
  output ctrl_t ctrl
);

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;

  assign ctrl = ucode(step);

  always_comb begin
    case (ctrl.cond)
      COND_ACCEPT: step_next = in_valid ? ctrl.jmp_tgt : ctrl.nxt_tgt;
      COND_BODY: begin
        if (stat.esc) begin
          step_next = ctrl.esc_tgt;
        end else if (stat.at_end) begin
          step_next = ctrl.jmp_tgt;
        end else begin
          step_next = ctrl.nxt_tgt;
        end
      end
      default: step_next = ctrl.nxt_tgt;
    endcase
    if (!stat.adv) begin
      step_next = step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_WAIT;
    end else begin
      step <= step_next;
    end
  end

endmodule

@@ hdl/sft_datapath.sv @@
module sft_datapath
  import sft_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  ctrl_t                ctrl,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 in_valid,
  input  logic                 is_write,
  input  logic [15:0]          address,
  input  logic [31:0]          data_word,
  output stat_t                stat,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_byte,
  output logic                 last_byte
);

  logic [7:0]       read_code;
  logic [7:0]       write_code;
  logic [7:0]       state_byte;
  logic [7:0]       body [DATA_BYTES];
  logic [7:0]       sum;
  logic [POS_W-1:0] pos;
  logic [7:0]       cur_byte;
  logic [7:0]       byte_next;
  logic             out_free;
  logic             load;
  logic             esc_hit;
  logic             inc;

  assign out_free = !out_valid || !out_stall;
  assign load     = ctrl.accept && in_valid;

  // the checksum slot is the running sum itself
  assign cur_byte = (pos == POS_W'(DATA_BYTES)) ? sum : body[pos[IDX_W-1:0]];
  assign esc_hit  = ctrl.stuff &&
                    (cur_byte == STX_BYTE || cur_byte == ETX_BYTE || cur_byte == ESC_BYTE);
  assign inc      = ctrl.pos_inc && !esc_hit;

  assign stat.esc    = esc_hit;
  assign stat.at_end = (pos == POS_W'(DATA_BYTES));
  assign stat.adv    = !ctrl.emit || out_free;

  always_comb begin
    case (ctrl.src)
      SRC_STX:  byte_next = STX_BYTE;
      SRC_ETX:  byte_next = ETX_BYTE;
      SRC_ESC:  byte_next = ESC_BYTE;
      SRC_BODY: byte_next = esc_hit ? ESC_BYTE : cur_byte;
      SRC_XOR:  byte_next = cur_byte ^ ESC_XOR;
      default:  byte_next = ETX_BYTE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_code  <= 8'd0;
      write_code <= 8'd1;
      state_byte <= 8'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_READ_CODE:  read_code  <= cfg_data;
        REG_WRITE_CODE: write_code <= cfg_data;
        REG_STATE_BYTE: state_byte <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      body[0] <= is_write ? write_code : read_code;
      body[1] <= address[7:0];
      body[2] <= address[15:8];
      body[3] <= data_word[7:0];
      body[4] <= data_word[15:8];
      body[5] <= data_word[23:16];
      body[6] <= data_word[31:24];
      body[7] <= state_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      sum <= 8'd0;
    end else if (load) begin
      pos <= '0;
      sum <= 8'd0;
    end else if (inc && stat.adv) begin
      pos <= pos + POS_W'(1);
      if (pos != POS_W'(DATA_BYTES)) begin
        sum <= sum + cur_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= ctrl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && ctrl.emit) begin
      out_byte  <= byte_next;
      last_byte <= ctrl.last;
    end
  end

endmodule
